>>> hdl/mhoa_pkg.sv
// shared types and constants of the mesh overhang area block
`default_nettype none
package mhoa_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned EdgeW  = 25;
  localparam int unsigned CrossW = 51;
  localparam int unsigned MulW   = 27;
  localparam int unsigned ProdW  = 54;
  localparam int unsigned AccW   = 104;
  localparam int unsigned RadW   = 102;
  localparam int unsigned RootW  = 51;
  localparam int unsigned SumW   = 63;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_UP_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UP_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UP_Z = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COS  = 2'd3;

  localparam logic [SumW-1:0] SUM_MAX = {SumW{1'b1}};

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_25 = 2'd1,
    SH_26 = 2'd2,
    SH_50 = 2'd3
  } mac_shift_e;

  typedef struct packed {
    logic       clr;
    logic       sub;
    mac_shift_e sh;
  } mac_cmd_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic                     last_triangle;
  } tri_t;

  typedef struct packed {
    logic [SumW-1:0] total_area;
    logic [SumW-1:0] overhang_area;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/mhoa_stream_if.sv
// valid/ready stream interface carrying one word
`default_nettype none
interface mhoa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/mhoa_mac.sv
// shared 27x27 signed multiplier with shifted 104 bit accumulator
`default_nettype none
module mhoa_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire mhoa_pkg::mac_cmd_t                  cmd_i,
  input  wire logic signed [mhoa_pkg::MulW-1:0]    a_i,
  input  wire logic signed [mhoa_pkg::MulW-1:0]    b_i,
  output logic signed [mhoa_pkg::AccW-1:0]         acc_o
);
  import mhoa_pkg::*;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  ext;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_d, acc_q;

  always_comb begin
    prod = a_i * b_i;
    ext  = {{(AccW-ProdW){prod[ProdW-1]}}, prod};
    unique case (cmd_i.sh)
      SH_0:    term = ext;
      SH_25:   term = ext <<< 25;
      SH_26:   term = ext <<< 26;
      SH_50:   term = ext <<< 50;
      default: term = ext;
    endcase
    base  = cmd_i.clr ? '0 : acc_q;
    acc_d = cmd_i.sub ? base - term : base + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

>>> hdl/mhoa_isqrt.sv
// bit serial floor square root, two radicand bits per cycle
`default_nettype none
module mhoa_isqrt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [mhoa_pkg::RadW-1:0]       rad_i,
  output logic                                 done_o,
  output logic [mhoa_pkg::RootW-1:0]           root_o
);
  import mhoa_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW+1:0]  rem_t;
  logic [RemW+1:0]  trial;
  logic             ge;

  always_comb begin
    rem_t  = {rem_q, rad_q[RadW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_t >= trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 6'(RootW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      rem_d  = ge ? RemW'(rem_t - trial) : RemW'(rem_t);
      root_d = {root_q[RootW-2:0], ge};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

>>> hdl/mesh_overhang_area_core.sv
// top level: triangle area and overhang area accumulation
`default_nettype none
// mesh_overhang_area_core takes one triangle word (three Q12.12 vertices) and adds
// its area floor(sqrt(|n|^2)/2), n = (b-a) x (c-a), to a saturating total, and to
// a saturating overhang total when dot(n, up) < -cos_threshold * sqrt(|n|^2).
// a word flagged last_triangle yields one result word holding both totals, which
// then clear. every product goes through one shared 27x27 multiplier with a
// shifted accumulator, in turn for the cross product, |n|^2 and the overhang
// test; the square root between |n|^2 and the overhang test takes 2 bits per
// cycle. one triangle occupies the block until its area is summed, a last word
// also until a previous result is claimed; tri_i.ready is high only
// between triangles. a result word sits in an output register, so the next
// triangle is taken while it waits. coordinates use their low COORD_BITS bits,
// sign extended. configuration is written through cfg_we_i / cfg_idx_i.
module mesh_overhang_area_core #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mhoa_stream_if.sink                        tri_i,
  mhoa_stream_if.source                      res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mhoa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mhoa_pkg::CfgW-1:0]     cfg_wdata_i
);
  import mhoa_pkg::*;

  localparam int unsigned ExtSh = CoordW - COORD_BITS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CROSS  = 8'b0000_0010,
    S_SQ     = 8'b0000_0100,
    S_RSTART = 8'b0000_1000,
    S_ROOT   = 8'b0001_0000,
    S_DOT    = 8'b0010_0000,
    S_SUM    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  // coordinate trimmed to COORD_BITS and sign extended
  function automatic logic signed [CoordW-1:0] trim(input logic signed [CoordW-1:0] x);
    logic signed [CoordW-1:0] t;
    t = x <<< ExtSh;
    return t >>> ExtSh;
  endfunction

  function automatic logic [CrossW-1:0] mag(input logic signed [CrossW-1:0] x);
    return x[CrossW-1] ? CrossW'(-x) : CrossW'(x);
  endfunction

  function automatic logic signed [MulW-1:0] e27(input logic signed [EdgeW-1:0] x);
    return {{(MulW-EdgeW){x[EdgeW-1]}}, x};
  endfunction

  function automatic logic signed [MulW-1:0] u27(input logic signed [CfgW-1:0] x);
    return {{(MulW-CfgW){x[CfgW-1]}}, x};
  endfunction

  // unsigned high / low halves of a 51 bit magnitude
  function automatic logic signed [MulW-1:0] mhi(input logic [CrossW-1:0] x);
    return {1'b0, x[CrossW-1:25]};
  endfunction

  function automatic logic signed [MulW-1:0] mlo(input logic [CrossW-1:0] x);
    return {2'b00, x[24:0]};
  endfunction

  // signed high half / unsigned low half of a signed cross component
  function automatic logic signed [MulW-1:0] shi(input logic signed [CrossW-1:0] x);
    return {x[CrossW-1], x[CrossW-1:25]};
  endfunction

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  // config registers
  logic signed [CfgW-1:0] up_x_q, up_y_q, up_z_q, cos_q;

  // per triangle data
  logic signed [EdgeW-1:0]  e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [CrossW-1:0] nx_q, ny_q, nz_q;
  logic                     last_q;
  logic [CrossW-1:0]        mx, my, mz;

  // totals and result register
  logic [SumW-1:0] total_q, total_d, ovh_q, ovh_d;
  res_t            out_q;
  logic            out_valid_q;
  logic            out_load;

  // shared units
  mac_cmd_t                cmd;
  logic                    mac_en;
  logic signed [MulW-1:0]  op_a, op_b;
  logic signed [AccW-1:0]  acc;
  logic                    root_start, root_done;
  logic [RootW-1:0]        root;

  logic [SumW:0]           tsum, osum;
  logic [RootW-2:0]        area;
  logic                    accept;

  assign accept      = tri_i.valid && tri_i.ready;
  assign tri_i.ready = (state_q == S_IDLE);
  assign mx = mag(nx_q);
  assign my = mag(ny_q);
  assign mz = mag(nz_q);
  assign area = root[RootW-1:1];

  mhoa_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mac_en),
    .cmd_i  (cmd),
    .a_i    (op_a),
    .b_i    (op_b),
    .acc_o  (acc)
  );

  mhoa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (acc[RadW-1:0]),
    .done_o  (root_done),
    .root_o  (root)
  );

  // operand selection for the shared multiplier
  always_comb begin
    cmd    = '{clr: 1'b0, sub: 1'b0, sh: SH_0};
    op_a   = '0;
    op_b   = '0;
    mac_en = 1'b0;
    unique case (state_q)
      S_CROSS: begin
        // n = e1 x e2, two products per component
        mac_en  = 1'b1;
        cmd.clr = ~cnt_q[0];
        cmd.sub = cnt_q[0];
        unique case (cnt_q)
          4'd0:    begin op_a = e27(e1y_q); op_b = e27(e2z_q); end
          4'd1:    begin op_a = e27(e1z_q); op_b = e27(e2y_q); end
          4'd2:    begin op_a = e27(e1z_q); op_b = e27(e2x_q); end
          4'd3:    begin op_a = e27(e1x_q); op_b = e27(e2z_q); end
          4'd4:    begin op_a = e27(e1x_q); op_b = e27(e2y_q); end
          default: begin op_a = e27(e1y_q); op_b = e27(e2x_q); end
        endcase
      end
      S_SQ: begin
        // |n|^2 from hi*hi<<50 + 2*hi*lo<<25 + lo*lo per component
        mac_en  = 1'b1;
        cmd.clr = (cnt_q == 4'd0);
        unique case (cnt_q)
          4'd0:    begin op_a = mhi(mx); op_b = mhi(mx); cmd.sh = SH_50; end
          4'd1:    begin op_a = mhi(mx); op_b = mlo(mx); cmd.sh = SH_26; end
          4'd2:    begin op_a = mlo(mx); op_b = mlo(mx); end
          4'd3:    begin op_a = mhi(my); op_b = mhi(my); cmd.sh = SH_50; end
          4'd4:    begin op_a = mhi(my); op_b = mlo(my); cmd.sh = SH_26; end
          4'd5:    begin op_a = mlo(my); op_b = mlo(my); end
          4'd6:    begin op_a = mhi(mz); op_b = mhi(mz); cmd.sh = SH_50; end
          4'd7:    begin op_a = mhi(mz); op_b = mlo(mz); cmd.sh = SH_26; end
          default: begin op_a = mlo(mz); op_b = mlo(mz); end
        endcase
      end
      S_DOT: begin
        // dot(n, up) + len * cos, sign gives the overhang flag
        mac_en  = 1'b1;
        cmd.clr = (cnt_q == 4'd0);
        cmd.sh  = cnt_q[0] ? SH_0 : SH_25;
        unique case (cnt_q)
          4'd0:    begin op_a = shi(nx_q); op_b = u27(up_x_q); end
          4'd1:    begin op_a = mlo(nx_q); op_b = u27(up_x_q); end
          4'd2:    begin op_a = shi(ny_q); op_b = u27(up_y_q); end
          4'd3:    begin op_a = mlo(ny_q); op_b = u27(up_y_q); end
          4'd4:    begin op_a = shi(nz_q); op_b = u27(up_z_q); end
          4'd5:    begin op_a = mlo(nz_q); op_b = u27(up_z_q); end
          4'd6:    begin op_a = mhi(root); op_b = u27(cos_q); end
          default: begin op_a = mlo(root); op_b = u27(cos_q); end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    root_start = 1'b0;
    out_load   = 1'b0;
    tsum       = {1'b0, total_q} + (SumW+1)'(area);
    osum       = {1'b0, ovh_q} + (SumW+1)'(area);
    total_d    = total_q;
    ovh_d      = ovh_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) state_d = S_CROSS;
      end
      S_CROSS: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          cnt_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          cnt_d   = '0;
          state_d = S_RSTART;
        end
      end
      S_RSTART: begin
        root_start = 1'b1;
        state_d    = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) state_d = S_DOT;
      end
      S_DOT: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          cnt_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        total_d = tsum[SumW] ? SUM_MAX : tsum[SumW-1:0];
        if (acc[AccW-1]) ovh_d = osum[SumW] ? SUM_MAX : osum[SumW-1:0];
        state_d = last_q ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        // wait for the result register to free up, then hand over and clear
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          total_d  = '0;
          ovh_d    = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      ovh_q       <= '0;
      out_valid_q <= 1'b0;
      up_x_q      <= '0;
      up_y_q      <= '0;
      up_z_q      <= 16'sd32767;
      cos_q       <= 16'sd23170;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      ovh_q   <= ovh_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_UP_X: up_x_q <= cfg_wdata_i;
          CFG_UP_Y: up_y_q <= cfg_wdata_i;
          CFG_UP_Z: up_z_q <= cfg_wdata_i;
          CFG_COS:  cos_q  <= cfg_wdata_i;
          default:  ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      e1x_q  <= EdgeW'(trim(tri_i.payload.bx)) - EdgeW'(trim(tri_i.payload.ax));
      e1y_q  <= EdgeW'(trim(tri_i.payload.by)) - EdgeW'(trim(tri_i.payload.ay));
      e1z_q  <= EdgeW'(trim(tri_i.payload.bz)) - EdgeW'(trim(tri_i.payload.az));
      e2x_q  <= EdgeW'(trim(tri_i.payload.cx)) - EdgeW'(trim(tri_i.payload.ax));
      e2y_q  <= EdgeW'(trim(tri_i.payload.cy)) - EdgeW'(trim(tri_i.payload.ay));
      e2z_q  <= EdgeW'(trim(tri_i.payload.cz)) - EdgeW'(trim(tri_i.payload.az));
      last_q <= tri_i.payload.last_triangle;
    end
    // each component is read off the accumulator in the step after it completes
    if (state_q == S_CROSS && cnt_q == 4'd2) nx_q <= acc[CrossW-1:0];
    if (state_q == S_CROSS && cnt_q == 4'd4) ny_q <= acc[CrossW-1:0];
    if (state_q == S_SQ && cnt_q == 4'd0)    nz_q <= acc[CrossW-1:0];
    if (out_load) begin
      out_q.total_area    <= total_d == '0 ? total_q : total_q;
      out_q.overhang_area <= ovh_q;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

`ifndef SYNTHESIS
  a_ovh_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovh_q <= total_q)
    else $error("overhang total exceeds total area");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the hand-over step");

  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (total_q == '0 && ovh_q == '0))
    else $error("totals not cleared after result");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == S_ROOT))
    else $error("square root finished outside its step");
`endif
endmodule
`default_nettype wire
